FILE: rtl/core/cafs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contrast autofocus sweep package
// Shared phase codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package cafs_pkg;

   // Per-camera autofocus phase.
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SWEEP = 2'd1,
      PH_HOLD  = 2'd2
   } phase_type;

   // Register indexes on the CSR write port.
   typedef enum logic [2:0] {
      CSR_COARSE_STEP     = 3'd0,
      CSR_FINE_STEP       = 3'd1,
      CSR_WORSE_LIMIT     = 3'd2,
      CSR_RETRIG_RATIO    = 3'd3,
      CSR_RETRIG_COUNT    = 3'd4,
      CSR_BACKOFF_TICKS   = 3'd5,
      CSR_AF_DURING_REC   = 3'd6
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int LENS_POS_W  = 10;
   localparam int SCORE_W     = 32;
   localparam int STREAK_W    = 8;
   localparam int RATIO_W     = 9;

   // Register reset values.
   localparam logic [9:0] COARSE_STEP_RST   = 10'd64;
   localparam logic [9:0] FINE_STEP_RST     = 10'd8;
   localparam logic [7:0] WORSE_LIMIT_RST   = 8'd3;
   localparam logic [8:0] RETRIG_RATIO_RST  = 9'd204;
   localparam logic [7:0] RETRIG_COUNT_RST  = 8'd3;
   localparam logic [7:0] BACKOFF_TICKS_RST = 8'd5;
   localparam logic       AF_DURING_REC_RST = 1'b0;

   // Saturating limit of the streak counters.
   localparam logic [7:0] STREAK_MAX = 8'd255;

endpackage

FILE: rtl/core/cafs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when not read.
// ----------------------------------------------------------------------------
module cafs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/contrast_autofocus_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contrast autofocus sweep
// Per-camera coarse/fine hill-climb autofocus with hold and re-trigger.
// ----------------------------------------------------------------------------
// The block takes one tick word per cycle while req_stall is low and returns
// one result word for each tick through the update stage and output register.
// The per-camera state sits in a small state RAM: a tick reads its entry at
// acceptance; the update stage updates it and writes it back when it advances,
// as the result loads into the output register. A tick that follows a tick for
// the same camera picks up the written entry by forwarding, so ticks may
// arrive back to back for any camera order. Entries come out of reset in the
// cleared state through per-entry valid bits; no clearing pass is needed.
// Configuration registers are written through the CSR port, which is always
// ready and should only be used while no tick is in flight.
// ----------------------------------------------------------------------------
module contrast_autofocus_sweep
   import cafs_pkg::*;
#(
   parameter int CAMERAS      = 4,
   parameter int MAX_POSITION = 1023
) (
   input  logic                   clock,
   input  logic                   reset,

   // Tick input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_camera,
   input  logic                   req_lens_present,
   input  logic                   req_recording,
   input  logic                   req_auto_mode,
   input  logic                   req_healthy,
   input  logic                   req_score_valid,
   input  logic [SCORE_W-1:0]     req_score,
   input  logic                   req_write_ok,

   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_command_valid,
   output logic [LENS_POS_W-1:0]  rsp_command_position,
   output logic [1:0]             rsp_phase,
   output logic                   rsp_fine_active,
   output logic [LENS_POS_W-1:0]  rsp_peak_position,

   // CSR write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
   localparam int POS_W  = $clog2(MAX_POSITION + 1);
   localparam int SUM_W  = ((POS_W > 10) ? POS_W : 10) + 1;
   localparam int PROD_W = SCORE_W + RATIO_W;

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_POSITION);

   // One camera's state entry.
   typedef struct packed {
      phase_type                phase;
      logic [POS_W-1:0]         target;
      logic [9:0]               step;
      logic [POS_W-1:0]         stage_end;
      logic [POS_W-1:0]         best_pos;
      logic                     best_none;
      logic [SCORE_W-1:0]       peak_score;
      logic [STREAK_W-1:0]      worse;
      logic                     fine;
      logic                     awaiting;
      logic [SCORE_W-1:0]       conv;
      logic [STREAK_W-1:0]      drop;
      logic [7:0]               backoff;
   } cam_entry_type;

   localparam int ENTRY_W = $bits(cam_entry_type);

   // Configuration registers.
   logic [9:0]          coarse_step_ff;
   logic [9:0]          fine_step_ff;
   logic [7:0]          worse_limit_ff;
   logic [RATIO_W-1:0]  retrig_ratio_ff;
   logic [7:0]          retrig_count_ff;
   logic [7:0]          backoff_ticks_ff;
   logic                af_during_rec_ff;

   // Update stage registers.
   logic                s1_valid_ff, s1_valid_in;
   logic [1:0]          s1_camera_ff;
   logic                s1_lens_ff;
   logic                s1_rec_ff;
   logic                s1_auto_ff;
   logic                s1_healthy_ff;
   logic                s1_score_valid_ff;
   logic [SCORE_W-1:0]  s1_score_ff;
   logic                s1_write_ok_ff;
   logic                s1_fwd_ff;
   cam_entry_type       s1_fwd_data_ff;
   logic                s1_known_ff;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_cmd_valid_ff;
   logic [LENS_POS_W-1:0] rsp_cmd_pos_ff;
   phase_type           rsp_phase_ff;
   logic                rsp_fine_ff;
   logic [LENS_POS_W-1:0] rsp_peak_ff;

   // Entry valid bits, cleared by reset.
   logic [(1 << ADDR_W)-1:0] entry_ok_ff;

   logic                req_accept;
   logic                s1_adv;
   logic [ADDR_W-1:0]   req_addr;
   logic [ADDR_W-1:0]   s1_addr;
   logic                s1_in_range;

   logic                wr_en;
   cam_entry_type       wr_data;
   logic [ENTRY_W-1:0]  ram_rd_data;

   cam_entry_type       clear_entry;
   cam_entry_type       cur;
   cam_entry_type       nxt;
   logic                cmd_valid;
   logic [POS_W-1:0]    cmd_pos;

   // Sweep arithmetic.
   logic                better;
   logic [SCORE_W-1:0]  peak_score_new;
   logic [POS_W-1:0]    best_pos_new;
   logic [STREAK_W-1:0] worse_new;
   logic                stage_over;
   logic [SUM_W-1:0]    next_sum;
   logic [SUM_W-1:0]    win_hi_sum;
   logic [POS_W-1:0]    win_lo;
   logic [PROD_W-1:0]   floor_prod;
   logic [PROD_W-1:0]   score_scaled;
   logic                below_floor;
   logic [STREAK_W-1:0] drop_new;

   // Handshake and stage flow.
   assign s1_adv      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !s1_adv;
   assign req_accept  = req_valid && !req_stall;
   assign req_addr    = ADDR_W'(req_camera);
   assign s1_addr     = ADDR_W'(s1_camera_ff);
   assign s1_in_range = ({30'd0, s1_camera_ff} < 32'(CAMERAS));
   assign csr_ready   = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coarse_step_ff   <= COARSE_STEP_RST;
         fine_step_ff     <= FINE_STEP_RST;
         worse_limit_ff   <= WORSE_LIMIT_RST;
         retrig_ratio_ff  <= RETRIG_RATIO_RST;
         retrig_count_ff  <= RETRIG_COUNT_RST;
         backoff_ticks_ff <= BACKOFF_TICKS_RST;
         af_during_rec_ff <= AF_DURING_REC_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_COARSE_STEP:   coarse_step_ff   <= csr_data;
            CSR_FINE_STEP:     fine_step_ff     <= csr_data;
            CSR_WORSE_LIMIT:   worse_limit_ff   <= csr_data[7:0];
            CSR_RETRIG_RATIO:  retrig_ratio_ff  <= csr_data[RATIO_W-1:0];
            CSR_RETRIG_COUNT:  retrig_count_ff  <= csr_data[7:0];
            CSR_BACKOFF_TICKS: backoff_ticks_ff <= csr_data[7:0];
            CSR_AF_DURING_REC: af_during_rec_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // State RAM, one entry per camera.
   cafs_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (CAMERAS),
      .ADDR_W (ADDR_W)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // Control registers of the pipeline and valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         entry_ok_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            entry_ok_ff[s1_addr] <= 1'b1;
         end
      end
   end

   // Capture the tick word, plus forwarding when its entry is written now.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_camera_ff      <= req_camera;
         s1_lens_ff        <= req_lens_present;
         s1_rec_ff         <= req_recording;
         s1_auto_ff        <= req_auto_mode;
         s1_healthy_ff     <= req_healthy;
         s1_score_valid_ff <= req_score_valid;
         s1_score_ff       <= req_score;
         s1_write_ok_ff    <= req_write_ok;
         s1_fwd_ff         <= wr_en && (s1_addr == req_addr);
         s1_fwd_data_ff    <= wr_data;
         s1_known_ff       <= entry_ok_ff[req_addr];
      end
   end

   // Cleared entry.
   always_comb begin
      clear_entry           = '0;
      clear_entry.phase     = PH_IDLE;
      clear_entry.best_none = 1'b1;
   end

   // Current entry: forwarded, stored, or the cleared state if never written.
   always_comb begin
      if (s1_fwd_ff) begin
         cur = s1_fwd_data_ff;
      end else if (s1_known_ff) begin
         cur = cam_entry_type'(ram_rd_data);
      end else begin
         cur = clear_entry;
      end
   end

   // Score bookkeeping for a sweep sample.
   always_comb begin
      better         = cur.best_none || (s1_score_ff > cur.peak_score);
      peak_score_new = better ? s1_score_ff : cur.peak_score;
      best_pos_new   = better ? cur.target : cur.best_pos;
      if (better) begin
         worse_new = '0;
      end else begin
         worse_new = (cur.worse < STREAK_MAX) ? cur.worse + 8'd1 : STREAK_MAX;
      end
      stage_over = (cur.target >= cur.stage_end) || (worse_new >= worse_limit_ff);
      next_sum   = SUM_W'(cur.target) + SUM_W'(cur.step);
      win_hi_sum = SUM_W'(best_pos_new) + SUM_W'(coarse_step_ff);
      if (SUM_W'(best_pos_new) > SUM_W'(coarse_step_ff)) begin
         win_lo = POS_W'(SUM_W'(best_pos_new) - SUM_W'(coarse_step_ff));
      end else begin
         win_lo = '0;
      end
   end

   // Hold floor test: score * 256 < converged * ratio.
   always_comb begin
      floor_prod   = PROD_W'(cur.conv) * PROD_W'(retrig_ratio_ff);
      score_scaled = PROD_W'({s1_score_ff, 8'd0});
      below_floor  = score_scaled < floor_prod;
      if (below_floor) begin
         drop_new = (cur.drop < STREAK_MAX) ? cur.drop + 8'd1 : STREAK_MAX;
      end else begin
         drop_new = '0;
      end
   end

   // Per-camera update.
   always_comb begin
      nxt       = cur;
      cmd_valid = 1'b0;
      cmd_pos   = '0;
      if (s1_lens_ff) begin
         if (!af_during_rec_ff && s1_rec_ff) begin
            if (cur.phase == PH_SWEEP) begin
               nxt = clear_entry;
            end
         end else if (!s1_auto_ff) begin
            if (cur.phase != PH_IDLE) begin
               nxt = clear_entry;
            end
         end else if (!s1_healthy_ff) begin
            if (cur.phase == PH_SWEEP) begin
               nxt = clear_entry;
            end
         end else if (cur.backoff != 8'd0) begin
            nxt.backoff = cur.backoff - 8'd1;
         end else begin
            case (cur.phase)
               PH_IDLE: begin
                  // Start a coarse sweep from position zero.
                  nxt           = clear_entry;
                  nxt.phase     = PH_SWEEP;
                  nxt.step      = coarse_step_ff;
                  nxt.stage_end = MAX_POS;
                  cmd_valid     = 1'b1;
                  cmd_pos       = '0;
                  nxt.awaiting  = s1_write_ok_ff;
                  if (!s1_write_ok_ff) begin
                     nxt.backoff = backoff_ticks_ff;
                  end
               end
               PH_SWEEP: begin
                  if (!cur.awaiting) begin
                     // Retry the pending move.
                     cmd_valid    = 1'b1;
                     cmd_pos      = cur.target;
                     nxt.awaiting = s1_write_ok_ff;
                     if (!s1_write_ok_ff) begin
                        nxt.backoff = backoff_ticks_ff;
                     end
                  end else if (s1_score_valid_ff) begin
                     nxt.peak_score = peak_score_new;
                     nxt.best_none  = 1'b0;
                     nxt.best_pos   = best_pos_new;
                     nxt.worse      = worse_new;
                     if (!stage_over) begin
                        // Step to the next position of this stage.
                        if (next_sum < SUM_W'(cur.stage_end)) begin
                           nxt.target = POS_W'(next_sum);
                        end else begin
                           nxt.target = cur.stage_end;
                        end
                        cmd_valid    = 1'b1;
                        cmd_pos      = nxt.target;
                        nxt.awaiting = s1_write_ok_ff;
                        if (!s1_write_ok_ff) begin
                           nxt.backoff = backoff_ticks_ff;
                        end
                     end else if (!cur.fine) begin
                        // Open the fine window around the coarse peak.
                        nxt.fine = 1'b1;
                        if (win_hi_sum < SUM_W'(MAX_POS)) begin
                           nxt.stage_end = POS_W'(win_hi_sum);
                        end else begin
                           nxt.stage_end = MAX_POS;
                        end
                        nxt.target     = win_lo;
                        nxt.step       = fine_step_ff;
                        nxt.best_none  = 1'b1;
                        nxt.peak_score = '0;
                        nxt.worse      = '0;
                        cmd_valid      = 1'b1;
                        cmd_pos        = win_lo;
                        nxt.awaiting   = s1_write_ok_ff;
                        if (!s1_write_ok_ff) begin
                           nxt.backoff = backoff_ticks_ff;
                        end
                     end else begin
                        // Command the peak; hold only once the write lands.
                        cmd_valid = 1'b1;
                        cmd_pos   = best_pos_new;
                        if (s1_write_ok_ff) begin
                           nxt.phase = PH_HOLD;
                           nxt.conv  = peak_score_new;
                           nxt.drop  = '0;
                        end else begin
                           nxt.backoff = backoff_ticks_ff;
                        end
                     end
                  end
               end
               PH_HOLD: begin
                  if (s1_score_valid_ff) begin
                     nxt.drop = drop_new;
                     if (drop_new >= retrig_count_ff) begin
                        nxt = clear_entry;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign wr_en   = s1_adv && s1_in_range;
   assign wr_data = nxt;

   // Output register.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         if (s1_in_range) begin
            rsp_cmd_valid_ff <= cmd_valid;
            rsp_cmd_pos_ff   <= cmd_valid ? LENS_POS_W'(cmd_pos) : '0;
            rsp_phase_ff     <= nxt.phase;
            rsp_fine_ff      <= nxt.fine;
            rsp_peak_ff      <= LENS_POS_W'(nxt.best_pos);
         end else begin
            rsp_cmd_valid_ff <= 1'b0;
            rsp_cmd_pos_ff   <= '0;
            rsp_phase_ff     <= PH_IDLE;
            rsp_fine_ff      <= 1'b0;
            rsp_peak_ff      <= '0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_command_valid    = rsp_cmd_valid_ff;
   assign rsp_command_position = rsp_cmd_pos_ff;
   assign rsp_phase            = rsp_phase_ff;
   assign rsp_fine_active      = rsp_fine_ff;
   assign rsp_peak_position    = rsp_peak_ff;

   // A lens write is never reported for a camera left idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cmd_valid_ff) |->
         (rsp_phase_ff == PH_SWEEP || rsp_phase_ff == PH_HOLD))
      else $error("lens write reported with camera idle");

   // Without a lens write the reported position is zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_cmd_valid_ff) |-> (rsp_cmd_pos_ff == '0))
      else $error("command position nonzero without a write");

   // An idle entry written back is always fully cleared.
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && wr_data.phase == PH_IDLE) |->
         (!wr_data.fine && wr_data.best_none && !wr_data.awaiting))
      else $error("idle camera entry not cleared");

   // A stalled update stage holds its tick until the result side frees up.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_camera_ff)))
      else $error("update stage lost a tick while stalled");

endmodule
